@@ rtl/lpf_pkg.sv @@
package lpf_pkg;

   localparam int NUM_PIXELS = 64;
   localparam int PIX_AW     = 6;
   localparam int COUNT_W    = 7;

   typedef enum logic [2:0] {
      OP_SET_TARGET = 3'd0,
      OP_STOP       = 3'd1,
      OP_TICK       = 3'd2,
      OP_STOP_ALL   = 3'd3,
      OP_FADE_OUT   = 3'd4,
      OP_WRITE      = 3'd5,
      OP_READ       = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   localparam logic REG_BRIGHTNESS_SHIFT = 1'b0;
   localparam logic REG_FADE_IN_ONLY     = 1'b1;

   typedef struct packed {
      logic [2:0]        operation;
      logic [PIX_AW-1:0] pixel_index;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
   } req_type;

   typedef struct packed {
      logic               any_fading;
      logic [COUNT_W-1:0] stopped_count;
      logic [7:0]         pixel_red;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_blue;
   } rsp_type;

   typedef struct packed {
      logic       fading;
      logic [5:0] target;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_entry_type;

   localparam int PIX_W = $bits(pix_entry_type);

   typedef struct packed {
      logic [2:0] operation;
      logic [1:0] shift;
      logic       fade_in_only;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } alu_ctrl_type;

   typedef struct packed {
      pix_entry_type entry;
      logic          stopped;
      logic          was_fading;
   } alu_res_type;

endpackage

@@ rtl/lpf_ram.sv @@
module lpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lpf_pixel_alu.sv @@
module lpf_pixel_alu (
   input  lpf_pkg::alu_ctrl_type  ctrl,
   input  lpf_pkg::pix_entry_type cur,
   output lpf_pkg::alu_res_type   res
);

   import lpf_pkg::*;

   function automatic logic [1:0] quant_ch(input logic [7:0] v, input logic [1:0] s);
      logic [7:0] w;
      w = v >> (3'd6 - {1'b0, s});
      return w[1:0];
   endfunction

   function automatic logic [7:0] expand_ch(input logic [1:0] c, input logic [1:0] s);
      logic [7:0] w;
      w = {c, 6'b000000} >> s;
      return w;
   endfunction

   function automatic logic [7:0] step_ch(input logic [7:0] v, input logic [7:0] t);
      logic [7:0] r;
      if (v > t) begin
         r = v - 8'd1;
      end else if (v < t) begin
         r = v + 8'd1;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [1:0] s_eff;
   logic [7:0] exp_r, exp_g, exp_b;
   logic [7:0] nxt_r, nxt_g, nxt_b;
   logic [7:0] base_r, base_g, base_b;
   logic [5:0] stop_code;
   logic       at_target;

   always_comb begin
      s_eff = (ctrl.shift == 2'd3) ? 2'd2 : ctrl.shift;
      exp_r = expand_ch(cur.target[5:4], s_eff);
      exp_g = expand_ch(cur.target[3:2], s_eff);
      exp_b = expand_ch(cur.target[1:0], s_eff);
      nxt_r = step_ch(cur.red, exp_r);
      nxt_g = step_ch(cur.green, exp_g);
      nxt_b = step_ch(cur.blue, exp_b);
      at_target = (nxt_r == exp_r) && (nxt_g == exp_g) && (nxt_b == exp_b);
      if (ctrl.operation == OP_TICK) begin
         base_r = nxt_r;
         base_g = nxt_g;
         base_b = nxt_b;
      end else begin
         base_r = cur.red;
         base_g = cur.green;
         base_b = cur.blue;
      end
      stop_code = {quant_ch(base_r, s_eff), quant_ch(base_g, s_eff), quant_ch(base_b, s_eff)};

      res = '0;
      res.entry = cur;
      case (ctrl.operation)
         OP_SET_TARGET: begin
            res.entry.target = {quant_ch(ctrl.red, s_eff), quant_ch(ctrl.green, s_eff),
                                quant_ch(ctrl.blue, s_eff)};
            res.entry.fading = 1'b1;
         end
         OP_STOP, OP_STOP_ALL: begin
            res.entry.target = stop_code;
            res.entry.red    = expand_ch(stop_code[5:4], s_eff);
            res.entry.green  = expand_ch(stop_code[3:2], s_eff);
            res.entry.blue   = expand_ch(stop_code[1:0], s_eff);
            res.entry.fading = 1'b0;
         end
         OP_TICK: begin
            if (cur.fading) begin
               res.was_fading  = 1'b1;
               res.entry.red   = nxt_r;
               res.entry.green = nxt_g;
               res.entry.blue  = nxt_b;
               if (at_target) begin
                  if ((cur.target == 6'd0) || ctrl.fade_in_only) begin
                     res.entry.target = stop_code;
                     res.entry.red    = expand_ch(stop_code[5:4], s_eff);
                     res.entry.green  = expand_ch(stop_code[3:2], s_eff);
                     res.entry.blue   = expand_ch(stop_code[1:0], s_eff);
                     res.entry.fading = 1'b0;
                     res.stopped      = 1'b1;
                  end else begin
                     res.entry.target = 6'd0;
                  end
               end
            end
         end
         OP_FADE_OUT: begin
            res.entry.target = 6'd0;
            res.entry.fading = 1'b1;
         end
         OP_WRITE: begin
            res.entry.red   = ctrl.red;
            res.entry.green = ctrl.green;
            res.entry.blue  = ctrl.blue;
         end
         default: begin
            res.entry = cur;
         end
      endcase
   end

endmodule

@@ rtl/led_pixel_fade_engine_top.sv @@
// Channel   Direction  Payload     Handshake
// req       in         req_type    req_valid / req_stall
// rsp       out        rsp_type    rsp_valid / rsp_stall
// csr       in/out     32-bit APB  csr_psel, csr_penable, csr_pwrite, csr_pready
//
// A transaction addresses one pixel, or, for tick, stop all and fade all out, every one of
// the NUM_PIXELS pixels; req_stall holds off the next one until the result is issued.
// The single state memory is read one pixel per cycle during a walk and each pixel is
// written back in the next cycle. Reset is synchronous; a valid bit per pixel makes every
// pixel read as black and not fading after reset, so no clearing pass is needed.
// A stalled result waits in the output register while the next transaction is taken.
module led_pixel_fade_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import lpf_pkg::*;

   localparam logic [PIX_AW-1:0] LAST_PIXEL = PIX_AW'(NUM_PIXELS - 1);

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic                issuing_ff, issuing_in;
   logic [PIX_AW-1:0]   issue_addr_ff, issue_addr_in;
   logic [PIX_AW-1:0]   last_addr_ff, last_addr_in;
   logic                pend_ff, pend_in;
   logic [PIX_AW-1:0]   pend_addr_ff, pend_addr_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [NUM_PIXELS-1:0] ent_valid_ff, ent_valid_in;
   rsp_type             acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [1:0]          shift_ff, shift_in;
   logic                fio_ff, fio_in;

   logic                req_accept;
   logic                idx_ok;
   logic                ram_we;
   logic                ram_re;
   logic [PIX_W-1:0]    ram_rd_data;
   pix_entry_type       rd_entry;
   pix_entry_type       cur_entry;
   alu_ctrl_type        alu_ctrl;
   alu_res_type         alu_res;
   logic                csr_write;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_FADE_IN_ONLY) ? {31'd0, fio_ff} : {30'd0, shift_ff};

   assign idx_ok    = ({1'b0, req_data.pixel_index} < (PIX_AW + 1)'(NUM_PIXELS));
   assign ram_re    = (state_ff == ST_WALK) && issuing_ff;
   assign ram_we    = (state_ff == ST_WALK) && pend_ff;
   assign rd_entry  = ram_rd_data;
   assign cur_entry = pend_valid_ff ? rd_entry : '0;

   assign alu_ctrl.operation    = req_ff.operation;
   assign alu_ctrl.shift        = shift_ff;
   assign alu_ctrl.fade_in_only = fio_ff;
   assign alu_ctrl.red          = req_ff.red;
   assign alu_ctrl.green        = req_ff.green;
   assign alu_ctrl.blue         = req_ff.blue;

   lpf_ram #(
      .WIDTH(PIX_W),
      .DEPTH(NUM_PIXELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_addr_ff),
      .wr_data (alu_res.entry),
      .rd_en   (ram_re),
      .rd_addr (issue_addr_ff),
      .rd_data (ram_rd_data)
   );

   lpf_pixel_alu u_alu (
      .ctrl (alu_ctrl),
      .cur  (cur_entry),
      .res  (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issuing_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         ent_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         shift_ff      <= 2'd0;
         fio_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issuing_ff    <= issuing_in;
         pend_ff       <= pend_in;
         ent_valid_ff  <= ent_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         shift_ff      <= shift_in;
         fio_ff        <= fio_in;
      end
      req_ff        <= req_in;
      issue_addr_ff <= issue_addr_in;
      last_addr_ff  <= last_addr_in;
      pend_addr_ff  <= pend_addr_in;
      pend_valid_ff <= pend_valid_in;
      acc_ff        <= acc_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      shift_in = shift_ff;
      fio_in   = fio_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_FADE_IN_ONLY) begin
            fio_in = csr_pwdata[0];
         end else begin
            shift_in = csr_pwdata[1:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      issuing_in    = issuing_ff;
      issue_addr_in = issue_addr_ff;
      last_addr_in  = last_addr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = issue_addr_ff;
      pend_valid_in = ent_valid_ff[issue_addr_ff];
      ent_valid_in  = ent_valid_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               acc_in   = '0;
               state_in = ST_WALK;
               if (req_data.operation inside {OP_TICK, OP_STOP_ALL, OP_FADE_OUT}) begin
                  issuing_in    = 1'b1;
                  issue_addr_in = '0;
                  last_addr_in  = LAST_PIXEL;
               end else if (req_data.operation inside {OP_SET_TARGET, OP_STOP, OP_WRITE,
                                                       OP_READ}) begin
                  issuing_in    = idx_ok;
                  issue_addr_in = req_data.pixel_index;
                  last_addr_in  = req_data.pixel_index;
               end else begin
                  issuing_in = 1'b0;
               end
            end
         end
         ST_WALK: begin
            if (issuing_ff) begin
               pend_in = 1'b1;
               if (issue_addr_ff == last_addr_ff) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_addr_in = issue_addr_ff + PIX_AW'(1);
               end
            end
            if (pend_ff) begin
               ent_valid_in[pend_addr_ff] = 1'b1;
               acc_in.any_fading    = acc_ff.any_fading | alu_res.was_fading;
               acc_in.stopped_count = acc_ff.stopped_count + COUNT_W'(alu_res.stopped);
               if (req_ff.operation == OP_READ) begin
                  acc_in.pixel_red   = cur_entry.red;
                  acc_in.pixel_green = cur_entry.green;
                  acc_in.pixel_blue  = cur_entry.blue;
               end
            end
            if (!issuing_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_WALK))
      else $error("no walk after an accepted transaction");

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_WALK))
      else $error("state memory written outside a walk");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!issuing_ff && !pend_ff))
      else $error("result issued while pixels are still in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a finished transaction");

endmodule
